// ===== design/pinhole_point_projection_core_macros.svh =====
// ----------------------------------------------------------------------------
// Pinhole projection assertion macros
// Shared property templates for the checker of the projection core.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_POINT_PROJECTION_CORE_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("projection core check failed");

// Next-cycle implication, checked outside reset.
`define PPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("projection core check failed");

`endif

// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection package
// Register map, configuration and sideband types, and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  // Restoring divider: one quotient bit per pipeline stage.
  localparam int DIV_STEPS = 64;

  // Quotient magnitude cap, 2^40.
  localparam logic [40:0] QUO_CAP = 41'(64'd1 << 40);

  // Register map, one register every eight bytes.
  typedef enum logic [2:0] {
    REG_ROT0  = 3'd0,
    REG_ROT1  = 3'd1,
    REG_ROT2  = 3'd2,
    REG_TXY   = 3'd3,
    REG_TZ    = 3'd4,
    REG_FOCAL = 3'd5,
    REG_PP    = 3'd6,
    REG_SKEW  = 3'd7
  } reg_idx_t;

  // Reset values: identity rotation, unit focal lengths.
  localparam logic [47:0] ROT0_RST  = 48'h0000_0000_4000;
  localparam logic [47:0] ROT1_RST  = 48'h0000_4000_0000;
  localparam logic [47:0] ROT2_RST  = 48'h4000_0000_0000;
  localparam logic [63:0] FOCAL_RST = 64'h0001_0000_0001_0000;

  typedef struct packed {
    logic [47:0] rot0;
    logic [47:0] rot1;
    logic [47:0] rot2;
    logic [63:0] txy;
    logic [31:0] tz;
    logic [63:0] focal;
    logic [63:0] pp;
    logic [31:0] skew;
  } cfg_t;

  // Per-item status that rides alongside the divider.
  typedef struct packed {
    logic        neg_u;
    logic        neg_v;
    logic        sat;
    logic        zero;
    logic [31:0] depth;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

`default_nettype wire

// ===== design/ppp_in_if.sv =====
// ----------------------------------------------------------------------------
// Point input channel
// Valid/ready channel carrying one 3D point item in Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ppp_out_if.sv =====
// ----------------------------------------------------------------------------
// Pixel result channel
// Valid/ready channel carrying one projected pixel item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_u;
  logic signed [31:0] pixel_v;
  logic signed [31:0] depth;
  logic               zero_depth;
  logic               saturated;

  modport source (output valid, output pixel_u, output pixel_v, output depth,
                  output zero_depth, output saturated, input ready);
  modport sink   (input valid, input pixel_u, input pixel_v, input depth,
                  input zero_depth, input saturated, output ready);
endinterface

`default_nettype wire

// ===== design/ppp_regs.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection registers
// APB-style register file holding pose and intrinsic parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output      logic [63:0]  prdata,
  output      logic         pready,
  output      ppp_pkg::cfg_t cfg
);

  ppp_pkg::cfg_t    cfg_r;
  ppp_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = ppp_pkg::reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot0  <= ppp_pkg::ROT0_RST;
      cfg_r.rot1  <= ppp_pkg::ROT1_RST;
      cfg_r.rot2  <= ppp_pkg::ROT2_RST;
      cfg_r.txy   <= '0;
      cfg_r.tz    <= '0;
      cfg_r.focal <= ppp_pkg::FOCAL_RST;
      cfg_r.pp    <= '0;
      cfg_r.skew  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ppp_pkg::REG_ROT0:  cfg_r.rot0  <= pwdata[47:0];
        ppp_pkg::REG_ROT1:  cfg_r.rot1  <= pwdata[47:0];
        ppp_pkg::REG_ROT2:  cfg_r.rot2  <= pwdata[47:0];
        ppp_pkg::REG_TXY:   cfg_r.txy   <= pwdata;
        ppp_pkg::REG_TZ:    cfg_r.tz    <= pwdata[31:0];
        ppp_pkg::REG_FOCAL: cfg_r.focal <= pwdata;
        ppp_pkg::REG_PP:    cfg_r.pp    <= pwdata;
        ppp_pkg::REG_SKEW:  cfg_r.skew  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (idx)
      ppp_pkg::REG_ROT0:  prdata = 64'(cfg_r.rot0);
      ppp_pkg::REG_ROT1:  prdata = 64'(cfg_r.rot1);
      ppp_pkg::REG_ROT2:  prdata = 64'(cfg_r.rot2);
      ppp_pkg::REG_TXY:   prdata = cfg_r.txy;
      ppp_pkg::REG_TZ:    prdata = 64'(cfg_r.tz);
      ppp_pkg::REG_FOCAL: prdata = cfg_r.focal;
      ppp_pkg::REG_PP:    prdata = cfg_r.pp;
      ppp_pkg::REG_SKEW:  prdata = 64'(cfg_r.skew);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ppp_xform.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection rigid transform
// Two stages: rotation products, then sum, shift, translate and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_xform (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] px,
  input  wire logic signed [31:0] py,
  input  wire logic signed [31:0] pz,
  input  wire ppp_pkg::cfg_t      cfg,
  output      logic               out_valid,
  output      logic signed [31:0] xc,
  output      logic signed [31:0] yc,
  output      logic signed [31:0] zc,
  output      logic               sat,
  output      logic               zero
);

  logic [47:0]        row [3];
  logic signed [31:0] pt [3];
  logic signed [31:0] tr [3];
  logic signed [15:0] coef [3][3];
  logic signed [47:0] prod_nxt [3][3];
  logic signed [47:0] prod_r [3][3];
  logic               s1_vld_r;
  logic signed [49:0] acc [3];
  logic signed [35:0] shf [3];
  logic signed [36:0] cam [3];
  logic signed [31:0] cam_nxt [3];
  logic signed [31:0] cam_r [3];
  logic               sat_nxt;
  logic               sat_r;
  logic               zero_r;
  logic               s2_vld_r;

  assign row[0] = cfg.rot0;
  assign row[1] = cfg.rot1;
  assign row[2] = cfg.rot2;
  assign pt[0]  = px;
  assign pt[1]  = py;
  assign pt[2]  = pz;
  assign tr[0]  = cfg.txy[31:0];
  assign tr[1]  = cfg.txy[63:32];
  assign tr[2]  = cfg.tz;

  // Stage 1: nine coefficient-by-coordinate products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j]     = row[i][16*j +: 16];
        prod_nxt[i][j] = coef[i][j] * pt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 2: exact row sums, floor shift, translation and clamp.
  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc[i]     = 50'(prod_r[i][0]) + 50'(prod_r[i][1]) + 50'(prod_r[i][2]);
      shf[i]     = acc[i][49:14];
      cam[i]     = 37'(shf[i]) + 37'(tr[i]);
      cam_nxt[i] = ppp_pkg::sat32(64'(cam[i]));
      sat_nxt    = sat_nxt | ppp_pkg::ovf32(64'(cam[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      cam_r  <= cam_nxt;
      sat_r  <= sat_nxt;
      zero_r <= (cam[2] == '0);
    end
  end

  assign out_valid = s2_vld_r;
  assign xc        = cam_r[0];
  assign yc        = cam_r[1];
  assign zc        = cam_r[2];
  assign sat       = sat_r;
  assign zero      = zero_r;

endmodule

`default_nettype wire

// ===== design/ppp_numer.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection numerators
// Three stages: intrinsic products, skew sum, then sign and magnitude split.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_numer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] xc,
  input  wire logic signed [31:0] yc,
  input  wire logic signed [31:0] zc,
  input  wire logic               sat,
  input  wire logic               zero,
  input  wire ppp_pkg::cfg_t      cfg,
  output      logic               out_valid,
  output      logic [63:0]        num_u,
  output      logic [63:0]        num_v,
  output      logic [31:0]        den,
  output      ppp_pkg::side_t     side
);

  logic signed [31:0] fx;
  logic signed [31:0] fy;
  logic signed [31:0] sk;
  logic signed [63:0] prod_a;
  logic signed [63:0] prod_b;
  logic signed [63:0] prod_c;

  logic               s3_vld_r;
  logic signed [63:0] s3_a_r;
  logic signed [63:0] s3_b_r;
  logic signed [63:0] s3_c_r;
  logic signed [31:0] s3_zc_r;
  logic               s3_sat_r;
  logic               s3_zero_r;

  logic               s4_vld_r;
  logic signed [64:0] s4_nu_nxt;
  logic signed [64:0] s4_nu_r;
  logic signed [63:0] s4_c_r;
  logic signed [31:0] s4_zc_r;
  logic               s4_sat_r;
  logic               s4_zero_r;

  logic               s5_vld_r;
  logic [63:0]        s5_mu_r;
  logic [63:0]        s5_mv_r;
  logic [31:0]        s5_den_r;
  ppp_pkg::side_t     s5_side_nxt;
  ppp_pkg::side_t     s5_side_r;

  assign fx = cfg.focal[31:0];
  assign fy = cfg.focal[63:32];
  assign sk = cfg.skew;

  // Stage 3: fx*xc, s*yc and fy*yc.
  assign prod_a = fx * xc;
  assign prod_b = sk * yc;
  assign prod_c = fy * yc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= in_valid;
    end
    if (adv) begin
      s3_a_r    <= prod_a;
      s3_b_r    <= prod_b;
      s3_c_r    <= prod_c;
      s3_zc_r   <= zc;
      s3_sat_r  <= sat;
      s3_zero_r <= zero;
    end
  end

  // Stage 4: exact u numerator.
  assign s4_nu_nxt = 65'(s3_a_r) + 65'(s3_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
    if (adv) begin
      s4_nu_r   <= s4_nu_nxt;
      s4_c_r    <= s3_c_r;
      s4_zc_r   <= s3_zc_r;
      s4_sat_r  <= s3_sat_r;
      s4_zero_r <= s3_zero_r;
    end
  end

  // Stage 5: magnitudes for the divider and quotient signs.
  always_comb begin
    s5_side_nxt.neg_u = s4_nu_r[64] ^ s4_zc_r[31];
    s5_side_nxt.neg_v = s4_c_r[63] ^ s4_zc_r[31];
    s5_side_nxt.sat   = s4_sat_r;
    s5_side_nxt.zero  = s4_zero_r;
    s5_side_nxt.depth = s4_zc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s5_vld_r <= s4_vld_r;
    end
    if (adv) begin
      s5_mu_r   <= s4_nu_r[64] ? 64'(-s4_nu_r) : 64'(s4_nu_r);
      s5_mv_r   <= s4_c_r[63] ? 64'(-s4_c_r) : 64'(s4_c_r);
      s5_den_r  <= s4_zc_r[31] ? 32'(-s4_zc_r) : 32'(s4_zc_r);
      s5_side_r <= s5_side_nxt;
    end
  end

  assign out_valid = s5_vld_r;
  assign num_u     = s5_mu_r;
  assign num_v     = s5_mv_r;
  assign den       = s5_den_r;
  assign side      = s5_side_r;

endmodule

`default_nettype wire

// ===== design/ppp_div.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection divider
// Pipelined restoring divider, two numerator lanes over one shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module ppp_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [63:0]    num_u,
  input  wire logic [63:0]    num_v,
  input  wire logic [31:0]    den,
  input  wire ppp_pkg::side_t side_in,
  output      logic           out_valid,
  output      logic [63:0]    quo_u,
  output      logic [63:0]    quo_v,
  output      ppp_pkg::side_t side_out
);

  localparam int N = ppp_pkg::DIV_STEPS;

  // Dividend bits shift out of nq at the top while quotient bits enter below.
  logic           vld_r  [1:N];
  logic [31:0]    rem_u_r[1:N];
  logic [31:0]    rem_v_r[1:N];
  logic [63:0]    nq_u_r [1:N];
  logic [63:0]    nq_v_r [1:N];
  logic [31:0]    den_r  [1:N];
  ppp_pkg::side_t side_r [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           src_vld;
    logic [31:0]    src_rem_u;
    logic [31:0]    src_rem_v;
    logic [63:0]    src_nq_u;
    logic [63:0]    src_nq_v;
    logic [31:0]    src_den;
    ppp_pkg::side_t src_side;
    logic [32:0]    trial_u;
    logic [32:0]    trial_v;
    logic           ge_u;
    logic           ge_v;

    if (k == 0) begin : g_first
      assign src_vld   = in_valid;
      assign src_rem_u = '0;
      assign src_rem_v = '0;
      assign src_nq_u  = num_u;
      assign src_nq_v  = num_v;
      assign src_den   = den;
      assign src_side  = side_in;
    end else begin : g_rest
      assign src_vld   = vld_r[k];
      assign src_rem_u = rem_u_r[k];
      assign src_rem_v = rem_v_r[k];
      assign src_nq_u  = nq_u_r[k];
      assign src_nq_v  = nq_v_r[k];
      assign src_den   = den_r[k];
      assign src_side  = side_r[k];
    end

    // One trial subtraction per lane.
    assign trial_u = {src_rem_u, src_nq_u[63]};
    assign trial_v = {src_rem_v, src_nq_v[63]};
    assign ge_u    = trial_u >= {1'b0, src_den};
    assign ge_v    = trial_v >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= src_vld;
      end
      if (adv) begin
        rem_u_r[k+1] <= ge_u ? 32'(trial_u - {1'b0, src_den}) : trial_u[31:0];
        rem_v_r[k+1] <= ge_v ? 32'(trial_v - {1'b0, src_den}) : trial_v[31:0];
        nq_u_r[k+1]  <= {src_nq_u[62:0], ge_u};
        nq_v_r[k+1]  <= {src_nq_v[62:0], ge_v};
        den_r[k+1]   <= src_den;
        side_r[k+1]  <= src_side;
      end
    end
  end

  assign out_valid = vld_r[N];
  assign quo_u     = nq_u_r[N];
  assign quo_v     = nq_v_r[N];
  assign side_out  = side_r[N];

endmodule

`default_nettype wire

// ===== design/pinhole_point_projection_core.sv =====
// ----------------------------------------------------------------------------
// Pinhole point projection core
// Projects Q16.16 world points through a rigid pose and a pinhole camera.
//
// Usage:
//   in_ch takes one point item (point_x/y/z) per valid/ready handshake.
//   out_ch gives one pixel item (pixel_u/v, depth, zero_depth, saturated)
//   for every point, in order.
//   The APB port (psel..pready, 64-bit data, register i at byte 8*i) holds
//   the pose and intrinsics; write it only while no item is in flight.
//   From input handshake to output valid, an item passes 2 transform
//   stages, 3 numerator stages, 64 divider stages (one quotient bit each)
//   and the output register. One item is accepted every cycle unless out_ch stalls.
//   When out_ch stalls with a result waiting, the whole pipeline holds and
//   in_ch.ready drops; no item is lost or repeated.
//   Synchronous active-low reset empties the pipeline and restores the
//   identity pose with unit focal lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_point_projection_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ppp_in_if.sink           in_ch,
  ppp_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready
);

  ppp_pkg::cfg_t      cfg;
  logic               adv;

  logic               xf_vld;
  logic signed [31:0] xc;
  logic signed [31:0] yc;
  logic signed [31:0] zc;
  logic               xf_sat;
  logic               xf_zero;

  logic               nm_vld;
  logic [63:0]        num_u;
  logic [63:0]        num_v;
  logic [31:0]        den;
  ppp_pkg::side_t     nm_side;

  logic               dv_vld;
  logic [63:0]        quo_u;
  logic [63:0]        quo_v;
  ppp_pkg::side_t     dv_side;

  logic [40:0]        cap_u;
  logic [40:0]        cap_v;
  logic signed [42:0] sq_u;
  logic signed [42:0] sq_v;
  logic signed [42:0] pix_u;
  logic signed [42:0] pix_v;
  logic signed [31:0] cx;
  logic signed [31:0] cy;

  logic               out_vld_r;
  logic signed [31:0] u_nxt;
  logic signed [31:0] v_nxt;
  logic signed [31:0] d_nxt;
  logic               sat_nxt;
  logic signed [31:0] u_r;
  logic signed [31:0] v_r;
  logic signed [31:0] d_r;
  logic               zero_r;
  logic               sat_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  ppp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppp_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .px        (in_ch.point_x),
    .py        (in_ch.point_y),
    .pz        (in_ch.point_z),
    .cfg       (cfg),
    .out_valid (xf_vld),
    .xc        (xc),
    .yc        (yc),
    .zc        (zc),
    .sat       (xf_sat),
    .zero      (xf_zero)
  );

  ppp_numer u_numer (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (xf_vld),
    .xc        (xc),
    .yc        (yc),
    .zc        (zc),
    .sat       (xf_sat),
    .zero      (xf_zero),
    .cfg       (cfg),
    .out_valid (nm_vld),
    .num_u     (num_u),
    .num_v     (num_v),
    .den       (den),
    .side      (nm_side)
  );

  ppp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (nm_vld),
    .num_u     (num_u),
    .num_v     (num_v),
    .den       (den),
    .side_in   (nm_side),
    .out_valid (dv_vld),
    .quo_u     (quo_u),
    .quo_v     (quo_v),
    .side_out  (dv_side)
  );

  assign cx = cfg.pp[31:0];
  assign cy = cfg.pp[63:32];

  // Final stage: cap, sign, principal point offset and clamp.
  always_comb begin
    cap_u = (quo_u > 64'(ppp_pkg::QUO_CAP)) ? ppp_pkg::QUO_CAP : quo_u[40:0];
    cap_v = (quo_v > 64'(ppp_pkg::QUO_CAP)) ? ppp_pkg::QUO_CAP : quo_v[40:0];
    sq_u  = dv_side.neg_u ? -(43'(cap_u)) : 43'(cap_u);
    sq_v  = dv_side.neg_v ? -(43'(cap_v)) : 43'(cap_v);
    pix_u = sq_u + 43'(cx);
    pix_v = sq_v + 43'(cy);
    if (dv_side.zero) begin
      u_nxt   = '0;
      v_nxt   = '0;
      d_nxt   = '0;
      sat_nxt = 1'b0;
    end else begin
      u_nxt   = ppp_pkg::sat32(64'(pix_u));
      v_nxt   = ppp_pkg::sat32(64'(pix_v));
      d_nxt   = dv_side.depth;
      sat_nxt = dv_side.sat | ppp_pkg::ovf32(64'(pix_u)) | ppp_pkg::ovf32(64'(pix_v));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld;
    end
    if (adv) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      d_r    <= d_nxt;
      zero_r <= dv_side.zero;
      sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.pixel_u    = u_r;
  assign out_ch.pixel_v    = v_r;
  assign out_ch.depth      = d_r;
  assign out_ch.zero_depth = zero_r;
  assign out_ch.saturated  = sat_r;

endmodule

`default_nettype wire

// ===== design/ppp_check.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection port checker
// Port-level properties of the projection core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pinhole_point_projection_core_macros.svh"

module ppp_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pixel_u,
  input wire logic [31:0] pixel_v,
  input wire logic [31:0] depth,
  input wire logic        zero_depth,
  input wire logic        saturated
);

  logic zero_fields;

  // All coordinates zero and no saturation reported.
  assign zero_fields = (pixel_u == 32'd0) && (pixel_v == 32'd0) && (depth == 32'd0) &&
                       !saturated;

  // A zero-depth item carries all-zero coordinates and no saturation.
  `PPP_ASSERT_NOW(a_zero_item, out_valid && zero_depth, zero_fields)

  // Any other item reports a nonzero depth.
  `PPP_ASSERT_NOW(a_depth_nonzero, out_valid && !zero_depth, depth != 32'd0)

  // An empty output register never blocks the input side.
  `PPP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // A stalled item holds its place and value.
  `PPP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pixel_u) && $stable(depth))

endmodule

bind pinhole_point_projection_core ppp_check u_ppp_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_u    (out_ch.pixel_u),
  .pixel_v    (out_ch.pixel_v),
  .depth      (out_ch.depth),
  .zero_depth (out_ch.zero_depth),
  .saturated  (out_ch.saturated)
);

`default_nettype wire

// ===== dv/tb_pinhole_point_projection_core.sv =====
// ----------------------------------------------------------------------------
// Pinhole projection core testbench
// Drives point items through the projection core under random source and
// sink idling, predicts each pixel item in a scoreboard and checks every
// field in order. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pinhole_point_projection_core;

  localparam int LATENCY   = 70;
  localparam int MAX_CYCLE = 1500000;

  // Expected pixel item.
  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] depth;
    logic        zero;
    logic        sat;
  } pixel_t;

  // Predicts pixel items from points and keeps them in arrival order.
  class projection_scoreboard;
    logic [47:0] rot [3];
    logic [63:0] txy, focal, pp;
    logic [31:0] tz, skew;
    pixel_t      pending [$];
    int          errors;

    function void reset_regs();
      rot[0] = ppp_pkg::ROT0_RST;
      rot[1] = ppp_pkg::ROT1_RST;
      rot[2] = ppp_pkg::ROT2_RST;
      txy    = '0;
      tz     = '0;
      focal  = ppp_pkg::FOCAL_RST;
      pp     = '0;
      skew   = '0;
    endfunction

    function void write_reg(ppp_pkg::reg_idx_t idx, logic [63:0] val);
      case (idx)
        ppp_pkg::REG_ROT0:  rot[0] = val[47:0];
        ppp_pkg::REG_ROT1:  rot[1] = val[47:0];
        ppp_pkg::REG_ROT2:  rot[2] = val[47:0];
        ppp_pkg::REG_TXY:   txy = val;
        ppp_pkg::REG_TZ:    tz = val[31:0];
        ppp_pkg::REG_FOCAL: focal = val;
        ppp_pkg::REG_PP:    pp = val;
        ppp_pkg::REG_SKEW:  skew = val[31:0];
        default: ;
      endcase
    endfunction

    // Row times point, floor-shifted by 14, plus translation.
    function logic signed [63:0] camera_axis(logic [47:0] row, logic signed [31:0] p [3],
                                             logic signed [31:0] t);
      logic signed [63:0] acc;
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += 64'(signed'(row[16*j +: 16])) * 64'(p[j]);
      end
      return (acc >>> 14) + 64'(t);
    endfunction

    function logic signed [63:0] clip32(logic signed [63:0] x, ref logic sat);
      if (x > 64'sd2147483647) begin
        sat = 1'b1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        sat = 1'b1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    // Truncating quotient with the magnitude cap of 2^40.
    function logic signed [63:0] cap_quotient(logic signed [65:0] n, logic signed [63:0] z);
      logic [65:0] nm;
      logic [63:0] zm, q;
      nm = n < 0 ? -n : n;
      zm = z < 0 ? -z : z;
      q  = 64'(nm / 66'(zm));
      if (q > 64'd1 << 40) begin
        q = 64'd1 << 40;
      end
      return ((n < 0) ^ (z < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      logic signed [31:0] p [3];
      logic signed [63:0] xc, yc, zc, u, v;
      logic signed [65:0] nu;
      logic               sat;
      pixel_t             r;
      p[0] = px; p[1] = py; p[2] = pz;
      sat = 1'b0;
      xc = camera_axis(rot[0], p, txy[31:0]);
      yc = camera_axis(rot[1], p, txy[63:32]);
      zc = camera_axis(rot[2], p, tz);
      if (zc == 0) begin
        r = '{u: '0, v: '0, depth: '0, zero: 1'b1, sat: 1'b0};
      end else begin
        xc = clip32(xc, sat);
        yc = clip32(yc, sat);
        zc = clip32(zc, sat);
        // The u numerator can reach 2^63, so it is formed two bits wider.
        nu = 66'(signed'(focal[31:0])) * 66'(xc) + 66'(signed'(skew)) * 66'(yc);
        u = clip32(cap_quotient(nu, zc) + 64'(signed'(pp[31:0])), sat);
        nu = 66'(signed'(focal[63:32])) * 66'(yc);
        v = clip32(cap_quotient(nu, zc) + 64'(signed'(pp[63:32])), sat);
        r = '{u: u[31:0], v: v[31:0], depth: zc[31:0], zero: 1'b0, sat: sat};
      end
      pending.push_back(r);
    endfunction

    function void check_pixel(logic [31:0] u, logic [31:0] v, logic [31:0] d,
                              logic z, logic s);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected pixel item u=%h v=%h depth=%h", u, v, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (u !== e.u) begin
        $error("pixel_u expected %h actual %h", e.u, u);
        errors++;
      end
      if (v !== e.v) begin
        $error("pixel_v expected %h actual %h", e.v, v);
        errors++;
      end
      if (d !== e.depth) begin
        $error("depth expected %h actual %h", e.depth, d);
        errors++;
      end
      if (z !== e.zero) begin
        $error("zero_depth expected %b actual %b", e.zero, z);
        errors++;
      end
      if (s !== e.sat) begin
        $error("saturated expected %b actual %b", e.sat, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_sink;
  longint      cycle;

  ppp_in_if  in_ch ();
  ppp_out_if out_ch ();

  projection_scoreboard sb;

  pinhole_point_projection_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_sink = 0;
    sb = new();
    sb.reset_regs();
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("pinhole_point_projection_core test failed");
      $finish;
    end
  end
  initial cycle = 0;

  // Sink: random ready, checks every accepted pixel item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_pixel(out_ch.pixel_u, out_ch.pixel_v, out_ch.depth,
                       out_ch.zero_depth, out_ch.saturated);
      end
      out_ch.ready <= !hold_sink && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(ppp_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(int'(idx) * 8); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offers one point and holds it until accepted; valid stays up for a
  // following item unless the sender idles.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_x <= x; in_ch.point_y <= y; in_ch.point_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(x, y, z);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Random 32-bit value biased toward edges and small magnitudes.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 16'h4000;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic random_setup(bit extreme);
    for (int r = 0; r < 3; r++) begin
      write_reg(ppp_pkg::reg_idx_t'(r),
                extreme ? {3{16'h8000}} : {rand_coef(), rand_coef(), rand_coef()});
    end
    write_reg(ppp_pkg::REG_TXY,
              extreme ? 64'h7FFF_FFFF_8000_0000 : {rand_coord(), rand_coord()});
    write_reg(ppp_pkg::REG_TZ, extreme ? 64'h7FFF_FFFF : {32'd0, rand_coord()});
    write_reg(ppp_pkg::REG_FOCAL,
              extreme ? 64'h8000_0000_7FFF_FFFF : {rand_coord(), rand_coord()});
    write_reg(ppp_pkg::REG_PP,
              extreme ? 64'h8000_0000_7FFF_FFFF : {rand_coord(), rand_coord()});
    write_reg(ppp_pkg::REG_SKEW, extreme ? 64'h8000_0000 : {32'd0, rand_coord()});
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    logic [31:0] edges [4];
    edges = '{32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity pose, zero depth, extreme corners, negative depth.
    send_idle_pct = 16; recv_idle_pct = 65;
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    send_point(32'hFFFF_0000, 32'h0003_0000, 32'hFFFE_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    foreach (edges[i]) begin
      foreach (edges[j]) begin
        send_point(edges[i], edges[j], edges[(i + j) % 4]);
      end
    end
    drain();

    // Extreme registers, including full-scale rotation.
    random_setup(1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    drain();

    // Random phases with changing idling.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 16; recv_idle_pct = 65;
      end else if (ph < 4) begin
        send_idle_pct = 65; recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_setup(1'b0);
      // Odd phases use a mild depth row, so depth is point z plus tz.
      if (ph % 2 == 1) begin
        write_reg(ppp_pkg::REG_ROT2, {16'h4000, 16'h0, 16'h0});
      end
      random_points(100);
      if (ph == 4) begin
        // Long sink stall while points keep coming.
        fork
          begin
            hold_sink = 1;
            repeat (300) @(posedge clk);
            hold_sink = 0;
          end
          random_points(100);
        join
      end else begin
        random_points(100);
      end
      // Pause the source until everything has come back.
      drain();
    end

    if (sb.errors == 0) begin
      $display("pinhole_point_projection_core test passed");
    end else begin
      $display("pinhole_point_projection_core test failed");
    end
    $finish;
  end
endmodule
